// ===== rtl/phs_pkg.sv =====
// shared constants, types and helpers for the packet header statistics block
package phs_pkg;

  localparam int TYPE_ENTRIES   = 16;
  localparam int HEADER_ENTRIES = 16;
  localparam int PAIR_ENTRIES   = 64;

  localparam int TYPE_IW   = (TYPE_ENTRIES > 1) ? $clog2(TYPE_ENTRIES) : 1;
  localparam int TYPE_CW   = $clog2(TYPE_ENTRIES + 1);
  localparam int HEADER_IW = (HEADER_ENTRIES > 1) ? $clog2(HEADER_ENTRIES) : 1;
  localparam int HEADER_CW = $clog2(HEADER_ENTRIES + 1);
  localparam int PAIR_IW   = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
  localparam int PAIR_CW   = $clog2(PAIR_ENTRIES + 1);

  localparam logic [15:0] ETH2_MIN_TYPE    = 16'h0600;
  localparam logic [7:0]  IPV4_HEADER_BYTE = 8'h45;
  localparam logic [7:0]  IPV6_HEADER_BYTE = 8'h60;
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;

  typedef struct packed {
    logic [15:0] len;
    logic [15:0] etype;
    logic        is_eth2;
    logic [7:0]  hfirst;
    logic        is_ipv4;
    logic        is_tcp;
    logic        is_udp;
    logic        is_icmp;
    logic [31:0] src;
    logic [31:0] dst;
  } job_t;

  typedef struct packed {
    logic [31:0] packets_seen;
    logic [31:0] bytes_seen;
    logic [31:0] ethernet_two_count;
    logic [31:0] ieee_8023_count;
    logic [31:0] ipv4_seen;
    logic [31:0] tcp_seen;
    logic [31:0] udp_seen;
    logic [31:0] icmp_seen;
    logic [31:0] type_entry_count;
    logic [31:0] header_byte_total;
    logic [31:0] pair_entry_count;
    logic        table_full;
  } result_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== rtl/phs_front.sv =====
// input stage: holds one header item and classifies it
module phs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [15:0]      frame_length,
  input  logic [7:0]       type_high,
  input  logic [7:0]       type_low,
  input  logic [7:0]       header_first,
  input  logic [7:0]       ip_protocol,
  input  logic [31:0]      source_address,
  input  logic [31:0]      dest_address,
  output logic             q_push,
  input  logic             q_full,
  output phs_pkg::job_t    q_data
);

  logic        valid;
  logic [15:0] len;
  logic [15:0] etype;
  logic [7:0]  hfirst;
  logic [7:0]  proto;
  logic [31:0] src;
  logic [31:0] dst;
  logic        take;

  assign full = valid && q_full;
  assign take = push && !full;
  assign q_push = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= take || (valid && q_full);
    end
    if (take) begin
      len    <= frame_length;
      etype  <= {type_high, type_low};
      hfirst <= header_first;
      proto  <= ip_protocol;
      src    <= source_address;
      dst    <= dest_address;
    end
  end

  always_comb begin
    q_data.len     = len;
    q_data.etype   = etype;
    q_data.is_eth2 = etype >= phs_pkg::ETH2_MIN_TYPE;
    q_data.hfirst  = hfirst;
    q_data.is_ipv4 = hfirst == phs_pkg::IPV4_HEADER_BYTE;
    q_data.is_tcp  = proto == phs_pkg::PROTO_TCP;
    q_data.is_udp  = proto == phs_pkg::PROTO_UDP;
    q_data.is_icmp = proto == phs_pkg::PROTO_ICMP;
    q_data.src     = src;
    q_data.dst     = dst;
  end

endmodule

// ===== rtl/phs_queue.sv =====
// two-entry queue of classified items between front and back
module phs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          q_full,
  input  phs_pkg::job_t wr_data,
  input  logic          pop,
  output logic          q_empty,
  output phs_pkg::job_t rd_data
);

  phs_pkg::job_t slots [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign q_full  = count == 2'd2;
  assign q_empty = count == 2'd0;
  assign do_push = push && !q_full;
  assign do_pop  = pop && !q_empty;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) slots[wp] <= wr_data;
  end

endmodule

// ===== rtl/phs_back.sv =====
// table walks, counters and result register
module phs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  output logic             q_pop,
  input  phs_pkg::job_t    q_data,
  output logic             empty,
  input  logic             pop,
  output phs_pkg::result_t res
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_TYPE = 5'b00010,
    B_HDR  = 5'b00100,
    B_PAIR = 5'b01000,
    B_DONE = 5'b10000
  } bstate_t;

  bstate_t state;
  bstate_t state_next;
  phs_pkg::job_t job;

  logic [31:0] pkt_cnt, byte_cnt, eth2_cnt, ieee_cnt, ipv4_cnt, tcp_cnt, udp_cnt, icmp_cnt;
  logic [31:0] type_val, hbyte_val, pair_val;
  logic        full_flag;
  logic        out_valid;

  logic [15:0] tkey   [phs_pkg::TYPE_ENTRIES];
  logic [31:0] tcount [phs_pkg::TYPE_ENTRIES];
  logic [phs_pkg::TYPE_CW-1:0] tfill, tidx;

  logic [7:0]  hkey   [phs_pkg::HEADER_ENTRIES];
  logic [31:0] htotal [phs_pkg::HEADER_ENTRIES];
  logic [phs_pkg::HEADER_CW-1:0] hfill, hidx;

  logic [95:0] pmem [phs_pkg::PAIR_ENTRIES];
  logic [95:0] pmem_q;
  logic [phs_pkg::PAIR_CW-1:0] pfill, ridx;
  logic [phs_pkg::PAIR_IW-1:0] pidx;
  logic        pend;
  logic        p_we;
  logic [phs_pkg::PAIR_IW-1:0] p_waddr;
  logic [95:0] p_wdata;

  logic [phs_pkg::TYPE_IW-1:0]   tsel;
  logic [phs_pkg::HEADER_IW-1:0] hsel;
  logic [31:0] t_inc, h_inc, p_inc;
  logic        p_hit;
  logic        out_free;

  assign tsel  = tidx[phs_pkg::TYPE_IW-1:0];
  assign hsel  = hidx[phs_pkg::HEADER_IW-1:0];
  assign t_inc = phs_pkg::sat_add(tcount[tsel], 32'd1);
  assign h_inc = phs_pkg::sat_add(htotal[hsel], {16'd0, job.len});
  assign p_inc = phs_pkg::sat_add(pmem_q[31:0], 32'd1);
  assign p_hit = pend && pmem_q[95:64] == job.src && pmem_q[63:32] == job.dst;
  assign out_free = !out_valid || pop;
  assign empty = !out_valid;
  assign q_pop = (state == B_IDLE) && !q_empty;

  always_comb begin
    state_next = state;
    p_we    = 1'b0;
    p_waddr = pidx;
    p_wdata = {job.src, job.dst, p_inc};
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_TYPE;
      B_TYPE: begin
        if (!job.is_eth2 || tidx == tfill || tkey[tsel] == job.etype) state_next = B_HDR;
      end
      B_HDR: begin
        if (hidx == hfill || hkey[hsel] == job.hfirst) state_next = B_PAIR;
      end
      B_PAIR: begin
        if (!job.is_ipv4) begin
          state_next = B_DONE;
        end else if (p_hit) begin
          p_we = 1'b1;
          state_next = B_DONE;
        end else if (!pend && ridx == pfill) begin
          p_we    = pfill != phs_pkg::PAIR_CW'(phs_pkg::PAIR_ENTRIES);
          p_waddr = pfill[phs_pkg::PAIR_IW-1:0];
          p_wdata = {job.src, job.dst, 32'd1};
          state_next = B_DONE;
        end
      end
      B_DONE: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // pair table memory, read data registered
  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    pmem_q <= pmem[ridx[phs_pkg::PAIR_IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      pkt_cnt   <= '0;
      byte_cnt  <= '0;
      eth2_cnt  <= '0;
      ieee_cnt  <= '0;
      ipv4_cnt  <= '0;
      tcp_cnt   <= '0;
      udp_cnt   <= '0;
      icmp_cnt  <= '0;
      tfill     <= '0;
      hfill     <= phs_pkg::HEADER_CW'(2);
      pfill     <= '0;
      pend      <= 1'b0;
      hkey[0]   <= phs_pkg::IPV4_HEADER_BYTE;
      hkey[1]   <= phs_pkg::IPV6_HEADER_BYTE;
      htotal[0] <= '0;
      htotal[1] <= '0;
    end else begin
      state <= state_next;
      // a result waiting in B_DONE is loaded into the output register
      out_valid <= (state == B_DONE) || (out_valid && !pop);
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job       <= q_data;
            tidx      <= '0;
            hidx      <= '0;
            ridx      <= '0;
            pend      <= 1'b0;
            type_val  <= '0;
            hbyte_val <= '0;
            pair_val  <= '0;
            full_flag <= 1'b0;
          end
        end
        B_TYPE: begin
          if (job.is_eth2) begin
            if (tidx == tfill) begin
              if (tfill != phs_pkg::TYPE_CW'(phs_pkg::TYPE_ENTRIES)) begin
                tkey[tsel]   <= job.etype;
                tcount[tsel] <= 32'd1;
                type_val     <= 32'd1;
                tfill        <= tfill + 1'b1;
              end else begin
                full_flag <= 1'b1;
              end
            end else if (tkey[tsel] == job.etype) begin
              tcount[tsel] <= t_inc;
              type_val     <= t_inc;
            end else begin
              tidx <= tidx + 1'b1;
            end
          end
        end
        B_HDR: begin
          if (hidx == hfill) begin
            if (hfill != phs_pkg::HEADER_CW'(phs_pkg::HEADER_ENTRIES)) begin
              hkey[hsel]   <= job.hfirst;
              htotal[hsel] <= {16'd0, job.len};
              hbyte_val    <= {16'd0, job.len};
              hfill        <= hfill + 1'b1;
            end else begin
              full_flag <= 1'b1;
            end
          end else if (hkey[hsel] == job.hfirst) begin
            htotal[hsel] <= h_inc;
            hbyte_val    <= h_inc;
          end else begin
            hidx <= hidx + 1'b1;
          end
        end
        B_PAIR: begin
          if (job.is_ipv4) begin
            if (p_hit) begin
              pair_val <= p_inc;
            end else if (!pend && ridx == pfill) begin
              if (p_we) begin
                pair_val <= 32'd1;
                pfill    <= pfill + 1'b1;
              end else begin
                full_flag <= 1'b1;
              end
            end else if (ridx != pfill) begin
              // issue the next read, compare lands in the next cycle
              pidx <= ridx[phs_pkg::PAIR_IW-1:0];
              ridx <= ridx + 1'b1;
              pend <= 1'b1;
            end else begin
              pend <= 1'b0;
            end
          end
        end
        B_DONE: begin
          if (out_free) begin
            pkt_cnt  <= phs_pkg::sat_add(pkt_cnt, 32'd1);
            byte_cnt <= phs_pkg::sat_add(byte_cnt, {16'd0, job.len});
            if (job.is_eth2) eth2_cnt <= phs_pkg::sat_add(eth2_cnt, 32'd1);
            else ieee_cnt <= phs_pkg::sat_add(ieee_cnt, 32'd1);
            if (job.is_ipv4) begin
              ipv4_cnt <= phs_pkg::sat_add(ipv4_cnt, 32'd1);
              if (job.is_tcp) tcp_cnt <= phs_pkg::sat_add(tcp_cnt, 32'd1);
              if (job.is_udp) udp_cnt <= phs_pkg::sat_add(udp_cnt, 32'd1);
              if (job.is_icmp) icmp_cnt <= phs_pkg::sat_add(icmp_cnt, 32'd1);
            end
            res.packets_seen       <= phs_pkg::sat_add(pkt_cnt, 32'd1);
            res.bytes_seen         <= phs_pkg::sat_add(byte_cnt, {16'd0, job.len});
            res.ethernet_two_count <= job.is_eth2 ? phs_pkg::sat_add(eth2_cnt, 32'd1)
                                                  : eth2_cnt;
            res.ieee_8023_count    <= job.is_eth2 ? ieee_cnt
                                                  : phs_pkg::sat_add(ieee_cnt, 32'd1);
            res.ipv4_seen <= job.is_ipv4 ? phs_pkg::sat_add(ipv4_cnt, 32'd1) : ipv4_cnt;
            res.tcp_seen  <= (job.is_ipv4 && job.is_tcp) ?
                             phs_pkg::sat_add(tcp_cnt, 32'd1) : tcp_cnt;
            res.udp_seen  <= (job.is_ipv4 && job.is_udp) ?
                             phs_pkg::sat_add(udp_cnt, 32'd1) : udp_cnt;
            res.icmp_seen <= (job.is_ipv4 && job.is_icmp) ?
                             phs_pkg::sat_add(icmp_cnt, 32'd1) : icmp_cnt;
            res.type_entry_count  <= type_val;
            res.header_byte_total <= hbyte_val;
            res.pair_entry_count  <= pair_val;
            res.table_full        <= full_flag;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/packet_header_statistics.sv =====
// top level of the packet header statistics block
//
//   channel   direction  handshake     transfer when
//   header    in         push / full   push && !full
//   result    out        empty / pop   pop && !empty
//
// in the back end an item walks the type table, the header table and the pair
// table, one entry per cycle (pair table through its registered read port);
// a new item is taken from the queue only in B_IDLE, after the last is done.
// reset is synchronous; the header table comes up with 0x45 and 0x60.
// the input stage and a two-entry queue keep taking items while a result waits.
module packet_header_statistics (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] frame_length,
  input  logic [7:0]  type_high,
  input  logic [7:0]  type_low,
  input  logic [7:0]  header_first,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] packets_seen,
  output logic [31:0] bytes_seen,
  output logic [31:0] ethernet_two_count,
  output logic [31:0] ieee_8023_count,
  output logic [31:0] ipv4_seen,
  output logic [31:0] tcp_seen,
  output logic [31:0] udp_seen,
  output logic [31:0] icmp_seen,
  output logic [31:0] type_entry_count,
  output logic [31:0] header_byte_total,
  output logic [31:0] pair_entry_count,
  output logic        table_full
);

  logic             f_push, q_full, q_empty, q_pop;
  phs_pkg::job_t    f_data, q_data;
  phs_pkg::result_t res;

  phs_front u_front (
    .clk, .rst, .push, .full, .frame_length, .type_high, .type_low, .header_first,
    .ip_protocol, .source_address, .dest_address,
    .q_push(f_push), .q_full(q_full), .q_data(f_data)
  );

  phs_queue u_queue (
    .clk, .rst, .push(f_push), .q_full(q_full), .wr_data(f_data),
    .pop(q_pop), .q_empty(q_empty), .rd_data(q_data)
  );

  phs_back u_back (
    .clk, .rst, .q_empty(q_empty), .q_pop(q_pop), .q_data(q_data),
    .empty, .pop, .res(res)
  );

  assign packets_seen       = res.packets_seen;
  assign bytes_seen         = res.bytes_seen;
  assign ethernet_two_count = res.ethernet_two_count;
  assign ieee_8023_count    = res.ieee_8023_count;
  assign ipv4_seen          = res.ipv4_seen;
  assign tcp_seen           = res.tcp_seen;
  assign udp_seen           = res.udp_seen;
  assign icmp_seen          = res.icmp_seen;
  assign type_entry_count   = res.type_entry_count;
  assign header_byte_total  = res.header_byte_total;
  assign pair_entry_count   = res.pair_entry_count;
  assign table_full         = res.table_full;

  a_pkt_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> packets_seen != 32'd0)
    else $error("result shows zero packets");

  a_class_sum: assert property (@(posedge clk) disable iff (rst)
    (!empty && packets_seen != 32'hFFFF_FFFF) |->
      ({1'b0, ethernet_two_count} + {1'b0, ieee_8023_count}) == {1'b0, packets_seen})
    else $error("frame classes do not add up to packets");

  a_tcp_le_ipv4: assert property (@(posedge clk) disable iff (rst)
    !empty |-> tcp_seen <= ipv4_seen)
    else $error("tcp count above ipv4 count");

endmodule
